### rtl/kruskal_union_find_edge_filter_core_macros.svh
// assertion helpers used by the core rtl
`ifndef KRUSKAL_UNION_FIND_EDGE_FILTER_CORE_MACROS_SVH
`define KRUSKAL_UNION_FIND_EDGE_FILTER_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define KUFE_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("kufe assertion failed");

// next-cycle implication, checked out of reset
`define KUFE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("kufe assertion failed");

`endif

### rtl/kufe_pkg.sv
`default_nettype none

package kufe_pkg;

    // fixed field widths
    localparam int MAX_VERTICES_DEF = 256;
    localparam int VTX_W            = 8;
    localparam int NV_W             = 9;
    localparam int CNT_W            = 9;
    localparam int RANK_W           = 4;
    localparam int STEP_W           = 5;

    localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;
    localparam logic [NV_W-1:0]   NV_RESET = 9'd256;

    // payload types
    typedef struct packed {
        logic             req_type;
        logic [VTX_W-1:0] first_vertex;
        logic [VTX_W-1:0] second_vertex;
    } t_in_item;

    typedef struct packed {
        logic [2:0]       status;
        logic [VTX_W-1:0] edges_taken;
        logic             tree_complete;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_CLEARED = 3'd0,
        ST_ADDED   = 3'd1,
        ST_SAME    = 3'd2,
        ST_IGNORED = 3'd3,
        ST_BAD     = 3'd4
    } t_status;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_CUR_U,
        OP_CUR_V,
        OP_RD_CUR,
        OP_FIND,
        OP_SAVE_A,
        OP_SAVE_B,
        OP_COMPRESS,
        OP_JOIN1,
        OP_JOIN2,
        OP_STAT,
        OP_CLR_INIT,
        OP_CLR_WR,
        OP_CLR_END,
        OP_EMIT
    } t_op;

    // jump conditions
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_IN,
        C_START,
        C_FULL,
        C_BAD,
        C_NOT_ROOT,
        C_CUR_ROOT,
        C_ROOTS_EQ,
        C_NOT_LAST,
        C_BOOT,
        C_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_op               op;
        t_cond             cond;
        logic [STEP_W-1:0] target;
        t_status           status;
    } t_uword;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic in_acc;
        logic is_start;
        logic tree_full;
        logic bad_vtx;
        logic not_root;
        logic cur_root;
        logic roots_eq;
        logic not_last;
        logic boot;
        logic out_busy;
    } t_flags;

    // program step addresses
    localparam logic [STEP_W-1:0] S_WAIT     = 5'd0;
    localparam logic [STEP_W-1:0] S_CHK_ST   = 5'd1;
    localparam logic [STEP_W-1:0] S_CHK_FULL = 5'd2;
    localparam logic [STEP_W-1:0] S_CHK_BAD  = 5'd3;
    localparam logic [STEP_W-1:0] S_F1_RD    = 5'd4;
    localparam logic [STEP_W-1:0] S_F1_CHK   = 5'd5;
    localparam logic [STEP_W-1:0] S_SAVE_A   = 5'd6;
    localparam logic [STEP_W-1:0] S_C1_RD    = 5'd7;
    localparam logic [STEP_W-1:0] S_C1_WR    = 5'd8;
    localparam logic [STEP_W-1:0] S_LD_V     = 5'd9;
    localparam logic [STEP_W-1:0] S_F2_RD    = 5'd10;
    localparam logic [STEP_W-1:0] S_F2_CHK   = 5'd11;
    localparam logic [STEP_W-1:0] S_SAVE_B   = 5'd12;
    localparam logic [STEP_W-1:0] S_C2_RD    = 5'd13;
    localparam logic [STEP_W-1:0] S_C2_WR    = 5'd14;
    localparam logic [STEP_W-1:0] S_CMP      = 5'd15;
    localparam logic [STEP_W-1:0] S_JOIN1    = 5'd16;
    localparam logic [STEP_W-1:0] S_JOIN2    = 5'd17;
    localparam logic [STEP_W-1:0] S_REJ      = 5'd18;
    localparam logic [STEP_W-1:0] S_IGN      = 5'd19;
    localparam logic [STEP_W-1:0] S_BADV     = 5'd20;
    localparam logic [STEP_W-1:0] S_CLR0     = 5'd21;
    localparam logic [STEP_W-1:0] S_CLR_W    = 5'd22;
    localparam logic [STEP_W-1:0] S_CLR_END  = 5'd23;
    localparam logic [STEP_W-1:0] S_RESP     = 5'd24;
    localparam logic [STEP_W-1:0] S_RET      = 5'd25;

    function automatic t_uword uw(input t_op op, input t_cond c,
                                  input logic [STEP_W-1:0] tgt, input t_status s);
        t_uword w;
        w.op     = op;
        w.cond   = c;
        w.target = tgt;
        w.status = s;
        return w;
    endfunction

    // control store: jump to target when cond holds, else fall through
    function automatic t_uword ucode(input logic [STEP_W-1:0] pc);
        t_uword w;
        unique case (pc)
            S_WAIT:     w = uw(OP_LATCH,    C_NO_IN,    S_WAIT,    ST_CLEARED);
            S_CHK_ST:   w = uw(OP_NONE,     C_START,    S_CLR0,    ST_CLEARED);
            S_CHK_FULL: w = uw(OP_NONE,     C_FULL,     S_IGN,     ST_CLEARED);
            S_CHK_BAD:  w = uw(OP_CUR_U,    C_BAD,      S_BADV,    ST_CLEARED);
            S_F1_RD:    w = uw(OP_RD_CUR,   C_NEVER,    S_WAIT,    ST_CLEARED);
            S_F1_CHK:   w = uw(OP_FIND,     C_NOT_ROOT, S_F1_RD,   ST_CLEARED);
            S_SAVE_A:   w = uw(OP_SAVE_A,   C_NEVER,    S_WAIT,    ST_CLEARED);
            S_C1_RD:    w = uw(OP_RD_CUR,   C_CUR_ROOT, S_LD_V,    ST_CLEARED);
            S_C1_WR:    w = uw(OP_COMPRESS, C_ALWAYS,   S_C1_RD,   ST_CLEARED);
            S_LD_V:     w = uw(OP_CUR_V,    C_NEVER,    S_WAIT,    ST_CLEARED);
            S_F2_RD:    w = uw(OP_RD_CUR,   C_NEVER,    S_WAIT,    ST_CLEARED);
            S_F2_CHK:   w = uw(OP_FIND,     C_NOT_ROOT, S_F2_RD,   ST_CLEARED);
            S_SAVE_B:   w = uw(OP_SAVE_B,   C_NEVER,    S_WAIT,    ST_CLEARED);
            S_C2_RD:    w = uw(OP_RD_CUR,   C_CUR_ROOT, S_CMP,     ST_CLEARED);
            S_C2_WR:    w = uw(OP_COMPRESS, C_ALWAYS,   S_C2_RD,   ST_CLEARED);
            S_CMP:      w = uw(OP_NONE,     C_ROOTS_EQ, S_REJ,     ST_CLEARED);
            S_JOIN1:    w = uw(OP_JOIN1,    C_NEVER,    S_WAIT,    ST_CLEARED);
            S_JOIN2:    w = uw(OP_JOIN2,    C_ALWAYS,   S_RESP,    ST_ADDED);
            S_REJ:      w = uw(OP_STAT,     C_ALWAYS,   S_RESP,    ST_SAME);
            S_IGN:      w = uw(OP_STAT,     C_ALWAYS,   S_RESP,    ST_IGNORED);
            S_BADV:     w = uw(OP_STAT,     C_ALWAYS,   S_RESP,    ST_BAD);
            S_CLR0:     w = uw(OP_CLR_INIT, C_NEVER,    S_WAIT,    ST_CLEARED);
            S_CLR_W:    w = uw(OP_CLR_WR,   C_NOT_LAST, S_CLR_W,   ST_CLEARED);
            S_CLR_END:  w = uw(OP_CLR_END,  C_BOOT,     S_WAIT,    ST_CLEARED);
            S_RESP:     w = uw(OP_EMIT,     C_OUT_BUSY, S_RESP,    ST_CLEARED);
            S_RET:      w = uw(OP_NONE,     C_ALWAYS,   S_WAIT,    ST_CLEARED);
            default:    w = uw(OP_NONE,     C_ALWAYS,   S_WAIT,    ST_CLEARED);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

### rtl/kufe_seq.sv
`default_nettype none

module kufe_seq
    import kufe_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_flags i_flags,
    output t_uword      o_ctl
);

    logic [STEP_W-1:0] r_pc;
    logic [STEP_W-1:0] n_pc;
    t_uword            w_word;
    logic              w_take;

    // control store lookup
    assign w_word = ucode(r_pc);
    assign o_ctl  = w_word;

    // jump condition select
    always_comb begin
        unique case (w_word.cond)
            C_NEVER:    w_take = 1'b0;
            C_ALWAYS:   w_take = 1'b1;
            C_NO_IN:    w_take = !i_flags.in_acc;
            C_START:    w_take = i_flags.is_start;
            C_FULL:     w_take = i_flags.tree_full;
            C_BAD:      w_take = i_flags.bad_vtx;
            C_NOT_ROOT: w_take = i_flags.not_root;
            C_CUR_ROOT: w_take = i_flags.cur_root;
            C_ROOTS_EQ: w_take = i_flags.roots_eq;
            C_NOT_LAST: w_take = i_flags.not_last;
            C_BOOT:     w_take = i_flags.boot;
            C_OUT_BUSY: w_take = i_flags.out_busy;
            default:    w_take = 1'b0;
        endcase
    end

    assign n_pc = w_take ? w_word.target : r_pc + 1'b1;

    // step counter, starts with the clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= S_CLR0;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

`default_nettype wire

### rtl/kufe_dp.sv
`default_nettype none

module kufe_dp
    import kufe_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire t_uword          i_ctl,
    input  wire logic            i_in_valid,
    input  wire t_in_item        i_in_data,
    input  wire logic            i_cfg_valid,
    input  wire logic [NV_W-1:0] i_cfg_data,
    input  wire logic            i_out_stall,
    output t_flags               o_flags,
    output logic                 o_out_valid,
    output t_out_item            o_out_data
);

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam logic [AW-1:0] LAST = AW'(MAX_VERTICES - 1);

    // forest storage
    logic [AW-1:0]     r_par_mem  [MAX_VERTICES];
    logic [RANK_W-1:0] r_rank_mem [MAX_VERTICES];
    logic [AW-1:0]     r_rd_par;
    logic [RANK_W-1:0] r_rd_rank;

    logic              r_boot;
    logic              r_out_valid;
    logic [NV_W-1:0]   r_nv;
    logic [CNT_W-1:0]  r_edge_count;
    t_in_item          r_in;
    logic [AW-1:0]     r_cur;
    logic [AW-1:0]     r_root;
    logic [RANK_W-1:0] r_rank;
    logic [AW-1:0]     r_ra;
    logic [RANK_W-1:0] r_rka;
    logic [AW-1:0]     r_rb;
    logic [RANK_W-1:0] r_rkb;
    t_status           r_status;
    t_out_item         r_out_data;

    logic [NV_W-1:0]   w_n;
    logic [NV_W-1:0]   w_target;
    logic              w_full;
    logic              w_bad;
    logic              w_in_acc;
    logic              w_out_busy;
    logic [AW-1:0]     w_u;
    logic [AW-1:0]     w_v;
    logic              w_we;
    logic              w_re;
    logic [AW-1:0]     w_waddr;
    logic [AW-1:0]     w_wpar;
    logic [RANK_W-1:0] w_wrank;

    // active vertex count, clamped to 1..MAX_VERTICES
    always_comb begin
        priority if (r_nv == '0) begin
            w_n = NV_W'(1);
        end else if (32'(r_nv) > MAX_VERTICES) begin
            w_n = NV_W'(MAX_VERTICES);
        end else begin
            w_n = r_nv;
        end
    end

    assign w_target   = w_n - 1'b1;
    assign w_full     = (r_edge_count >= w_target);
    assign w_bad      = ({1'b0, r_in.first_vertex} >= w_n)
                     || ({1'b0, r_in.second_vertex} >= w_n);
    assign w_u        = AW'(r_in.first_vertex);
    assign w_v        = AW'(r_in.second_vertex);
    assign w_in_acc   = i_in_valid && (i_ctl.op == OP_LATCH);
    assign w_out_busy = r_out_valid && i_out_stall;

    // status to the sequencer
    always_comb begin
        o_flags.in_acc    = w_in_acc;
        o_flags.is_start  = !r_in.req_type;
        o_flags.tree_full = w_full;
        o_flags.bad_vtx   = w_bad;
        o_flags.not_root  = (r_rd_par != r_cur);
        o_flags.cur_root  = (r_cur == r_root);
        o_flags.roots_eq  = (r_ra == r_rb);
        o_flags.not_last  = (r_cur != LAST);
        o_flags.boot      = r_boot;
        o_flags.out_busy  = w_out_busy;
    end

    // memory write and read port control
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_cur;
        w_wpar  = r_root;
        w_wrank = r_rd_rank;
        w_re    = (i_ctl.op == OP_RD_CUR);
        unique case (i_ctl.op)
            OP_COMPRESS: begin
                w_we = 1'b1;
            end
            OP_JOIN1: begin
                w_we = 1'b1;
                if (r_rka > r_rkb) begin
                    w_waddr = r_rb;
                    w_wpar  = r_ra;
                    w_wrank = r_rkb;
                end else begin
                    w_waddr = r_ra;
                    w_wpar  = r_rb;
                    w_wrank = r_rka;
                end
            end
            OP_JOIN2: begin
                // equal ranks: the surviving root grows, saturating
                w_we    = (r_rka == r_rkb) && (r_rkb != RANK_MAX);
                w_waddr = r_rb;
                w_wpar  = r_rb;
                w_wrank = r_rkb + 1'b1;
            end
            OP_CLR_WR: begin
                w_we    = 1'b1;
                w_wpar  = r_cur;
                w_wrank = '0;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    // forest memory, registered read
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_par_mem[w_waddr]  <= w_wpar;
            r_rank_mem[w_waddr] <= w_wrank;
        end
        if (w_re) begin
            r_rd_par  <= r_par_mem[r_cur];
            r_rd_rank <= r_rank_mem[r_cur];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_boot       <= 1'b1;
            r_out_valid  <= 1'b0;
            r_nv         <= NV_RESET;
            r_edge_count <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_nv <= i_cfg_data;
            end
            if (i_ctl.op == OP_CLR_END) begin
                r_boot <= 1'b0;
            end
            if (i_ctl.op == OP_CLR_INIT) begin
                r_edge_count <= '0;
            end else if (i_ctl.op == OP_JOIN2) begin
                r_edge_count <= r_edge_count + 1'b1;
            end
            if ((i_ctl.op == OP_EMIT) && !w_out_busy) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        unique case (i_ctl.op)
            OP_LATCH: begin
                if (w_in_acc) begin
                    r_in <= i_in_data;
                end
            end
            OP_CUR_U:    r_cur <= w_u;
            OP_CUR_V:    r_cur <= w_v;
            OP_FIND: begin
                r_cur  <= r_rd_par;
                r_root <= r_rd_par;
                r_rank <= r_rd_rank;
            end
            OP_SAVE_A: begin
                r_ra  <= r_root;
                r_rka <= r_rank;
                r_cur <= w_u;
            end
            OP_SAVE_B: begin
                r_rb  <= r_root;
                r_rkb <= r_rank;
                r_cur <= w_v;
            end
            OP_COMPRESS: r_cur <= r_rd_par;
            OP_JOIN2:    r_status <= i_ctl.status;
            OP_STAT:     r_status <= i_ctl.status;
            OP_CLR_INIT: r_cur <= '0;
            OP_CLR_WR:   r_cur <= r_cur + 1'b1;
            OP_CLR_END:  r_status <= i_ctl.status;
            OP_EMIT: begin
                if (!w_out_busy) begin
                    r_out_data.status        <= r_status;
                    r_out_data.edges_taken   <= r_edge_count[VTX_W-1:0];
                    r_out_data.tree_complete <= w_full;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

### rtl/kruskal_union_find_edge_filter_core.sv
// Kruskal edge filter over a disjoint-set forest (union by rank, path compression).
// Input channel (i_in_valid / o_in_stall, i_in_data): req_type 0 re-makes every
// vertex a singleton and clears the edge count; req_type 1 offers an edge.
// Each input gives exactly one result on the output channel (o_out_valid /
// i_out_stall, o_out_data): status, edges taken so far and tree complete.
// Config channel (i_cfg_valid / o_cfg_ready, i_cfg_data) sets num_vertices; write
// it only while the block is idle.
// One item at a time, run by a microcoded step sequencer over one memory port.
// Edge: each endpoint's root is found by walking its parent path, which is then
// compressed to point at the root; the two roots are compared, then joined by rank
// or the edge is rejected. The path lengths to the two roots are at most log2 of the
// vertex count. A full tree is reported as ignored before the vertices are checked.
// Start: the forest is swept one entry a cycle over all MAX_VERTICES entries.
// After reset the same sweep runs with o_in_stall high and gives no result.
// While the receiver stalls, the result is held and the next item can still be
// taken and worked on; its result waits until the output register frees.
`default_nettype none

`include "kruskal_union_find_edge_filter_core_macros.svh"

module kruskal_union_find_edge_filter_core
    import kufe_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    input  wire t_in_item        i_in_data,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output t_out_item            o_out_data,
    input  wire logic            i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire logic [NV_W-1:0] i_cfg_data
);

    t_uword w_ctl;
    t_flags w_flags;
    logic   w_out_added;
    logic   w_out_ignored;

    // input taken only while the program waits for work
    assign o_in_stall  = (w_ctl.op != OP_LATCH);
    assign o_cfg_ready = 1'b1;

    kufe_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_ctl   (w_ctl)
    );

    kufe_dp #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_flags     (w_flags),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    // result kinds seen by the checks
    assign w_out_added   = o_out_valid && (o_out_data.status == ST_ADDED);
    assign w_out_ignored = o_out_valid && (o_out_data.status == ST_IGNORED);

    // an accepted item keeps the input stalled while it is worked on
    `KUFE_ASSERT_NEXT(a_busy_after_transfer, i_in_valid && !o_in_stall, o_in_stall)
    // an added edge always leaves a nonzero count
    `KUFE_ASSERT_IMPL(a_added_counts, w_out_added, o_out_data.edges_taken != '0)
    // an ignored edge is only reported once the tree is complete
    `KUFE_ASSERT_IMPL(a_ignored_complete, w_out_ignored, o_out_data.tree_complete)

endmodule

`default_nettype wire

### test/tb_kruskal_union_find_edge_filter_core.sv
`timescale 1ns / 1ps

module tb_kruskal_union_find_edge_filter_core
    import kufe_pkg::*;
();

    localparam int unsigned FOREST_SIZE  = 256;
    localparam int unsigned SETTLE_CYCLES = 16;
    localparam int unsigned REPORT_LIMIT  = 10;
    localparam int          IN_W          = $bits(t_in_item);

    typedef enum int unsigned {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    logic            clk       = 1'b0;
    logic            rst_n     = 1'b0;
    logic            in_valid  = 1'b0;
    t_in_item        in_data   = '0;
    logic            out_stall = 1'b0;
    logic            cfg_valid = 1'b0;
    logic [NV_W-1:0] cfg_data  = '0;

    logic            o_in_stall;
    logic            o_out_valid;
    t_out_item       o_out_data;
    logic            o_cfg_ready;

    // requests waiting for the driver, verdicts waiting for the monitor
    t_in_item        pending_requests [$];
    t_out_item       expected_verdicts [$];

    int unsigned     send_idle_pct  = 0;
    int unsigned     recv_stall_pct = 0;
    int unsigned     mismatch_count = 0;

    // shadow forest
    logic [7:0]      forest_parent [FOREST_SIZE];
    logic [3:0]      forest_rank [FOREST_SIZE];
    int unsigned     taken_count;
    logic [NV_W-1:0] vertex_reg = NV_RESET;

    kruskal_union_find_edge_filter_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // every vertex back to a singleton set
    function automatic void clear_forest();
        for (int unsigned i = 0; i < FOREST_SIZE; i++) begin
            forest_parent[i] = i[7:0];
            forest_rank[i]   = '0;
        end
        taken_count = 0;
    endfunction

    // root walk, then point every vertex on the path straight at the root
    function automatic logic [7:0] find_root(input logic [7:0] v);
        logic [7:0] r;
        logic [7:0] cur;
        logic [7:0] nxt;
        r = v;
        while (forest_parent[r] != r) r = forest_parent[r];
        cur = v;
        while (cur != r) begin
            nxt                = forest_parent[cur];
            forest_parent[cur] = r;
            cur                = nxt;
        end
        return r;
    endfunction

    // expected verdict for one accepted request
    function automatic void filter_request(input t_in_item req);
        int unsigned n;
        int unsigned target;
        t_status     st;
        logic [7:0]  ru;
        logic [7:0]  rv;
        t_out_item   verdict;
        n = (vertex_reg == 0) ? 1 : ((vertex_reg > FOREST_SIZE) ? FOREST_SIZE : vertex_reg);
        target = n - 1;
        if (!req.req_type) begin
            clear_forest();
            st = ST_CLEARED;
        end else if (taken_count >= target) begin
            st = ST_IGNORED;
        end else if (req.first_vertex >= n || req.second_vertex >= n) begin
            st = ST_BAD;
        end else begin
            ru = find_root(req.first_vertex);
            rv = find_root(req.second_vertex);
            if (ru == rv) begin
                st = ST_SAME;
            end else begin
                // union by rank, rank saturating
                if (forest_rank[ru] > forest_rank[rv]) begin
                    forest_parent[rv] = ru;
                end else begin
                    forest_parent[ru] = rv;
                    if (forest_rank[ru] == forest_rank[rv] && forest_rank[rv] < RANK_MAX)
                        forest_rank[rv] = forest_rank[rv] + 4'd1;
                end
                taken_count++;
                st = ST_ADDED;
            end
        end
        verdict.status        = st;
        verdict.edges_taken   = taken_count[7:0];
        verdict.tree_complete = (taken_count >= target);
        expected_verdicts = {expected_verdicts, verdict};
    endfunction

    // request driver
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall)
                filter_request(in_data);
            if (!in_valid || !o_in_stall) begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_data  <= pending_requests.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // verdict monitor
    always @(posedge clk) begin
        t_out_item want;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) begin
                if (expected_verdicts.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("unexpected result: status %0d taken %0d complete %0d",
                                 o_out_data.status, o_out_data.edges_taken,
                                 o_out_data.tree_complete);
                end else begin
                    want = expected_verdicts.pop_front();
                    if (o_out_data.status !== want.status
                        || o_out_data.edges_taken !== want.edges_taken
                        || o_out_data.tree_complete !== want.tree_complete) begin
                        mismatch_count++;
                        // status, taken and complete on each side
                        if (mismatch_count <= REPORT_LIMIT)
                            $display("result mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                                     want.status, want.edges_taken, want.tree_complete,
                                     o_out_data.status, o_out_data.edges_taken,
                                     o_out_data.tree_complete);
                    end
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // wait for every transfer to finish, then let the sequencer settle
    task automatic wait_quiet();
        while (pending_requests.size() != 0 || in_valid || expected_verdicts.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_vertex_count(input logic [NV_W-1:0] value);
        wait_quiet();
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!o_cfg_ready);
        cfg_valid  <= 1'b0;
        vertex_reg  = value;
    endtask

    task automatic set_idling(input t_idle_mode mode);
        @(negedge clk);
        send_idle_pct  = (mode == IDLE_SENDER || mode == IDLE_BOTH) ?
                         ((mode == IDLE_BOTH) ? 22 : 73) : 0;
        recv_stall_pct = (mode == IDLE_RECEIVER || mode == IDLE_BOTH) ?
                         ((mode == IDLE_BOTH) ? 22 : 73) : 0;
    endtask

    task automatic push_edge(input logic [7:0] u, input logic [7:0] v);
        t_in_item req;
        req.req_type      = 1'b1;
        req.first_vertex  = u;
        req.second_vertex = v;
        pending_requests = {pending_requests, req};
    endtask

    task automatic push_start(input logic [7:0] u, input logic [7:0] v);
        t_in_item req;
        req.req_type      = 1'b0;
        req.first_vertex  = u;
        req.second_vertex = v;
        pending_requests = {pending_requests, req};
    endtask

    // one graph: a random spanning tree mixed with rejects, bad vertices and noise
    task automatic push_graph(input int unsigned n);
        int unsigned order [FOREST_SIZE];
        int unsigned i;
        int unsigned j;
        int unsigned tmp;
        int unsigned pick;
        logic [7:0]  a;
        logic [7:0]  b;
        t_in_item    noise;
        push_start(8'($urandom), 8'($urandom));
        for (i = 0; i < n; i++) order[i] = i;
        for (i = n - 1; i > 0; i--) begin
            j        = $urandom_range(i, 0);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (i = 1; i < n; i++) begin
            pick = $urandom_range(99);
            if (pick < 25) begin
                push_edge(8'($urandom_range(n - 1, 0)), 8'($urandom_range(n - 1, 0)));
            end else if (pick < 30 && n < FOREST_SIZE) begin
                a = 8'($urandom_range(FOREST_SIZE - 1, n));
                b = 8'($urandom_range(FOREST_SIZE - 1, 0));
                if ($urandom_range(1)) push_edge(a, b);
                else push_edge(b, a);
            end else if (pick < 32) begin
                noise = t_in_item'(IN_W'($urandom));
                pending_requests = {pending_requests, noise};
            end
            j = $urandom_range(i - 1, 0);
            if ($urandom_range(1)) push_edge(8'(order[i]), 8'(order[j]));
            else push_edge(8'(order[j]), 8'(order[i]));
        end
        // offers once the tree is done
        repeat ($urandom_range(3, 1)) push_edge(8'($urandom), 8'($urandom));
    endtask

    task automatic random_phase(input logic [NV_W-1:0] nv, input t_idle_mode mode,
                                input int unsigned budget);
        int unsigned n;
        int unsigned queued;
        write_vertex_count(nv);
        set_idling(mode);
        n = (nv == 0) ? 1 : ((nv > FOREST_SIZE) ? FOREST_SIZE : nv);
        queued = 0;
        while (queued < budget) begin
            push_graph(n);
            queued = pending_requests.size();
        end
    endtask

    // run limit
    initial begin
        #4000000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        clear_forest();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // reset vertex count: extremes of the vertex fields, self loop
        set_idling(IDLE_NONE);
        push_edge(8'd0, 8'd255);
        push_edge(8'd255, 8'd0);
        push_edge(8'd7, 8'd7);
        push_start(8'd255, 8'd255);

        // four vertices: bad vertices, full tree, ignored offers
        write_vertex_count(9'd4);
        @(negedge clk);
        push_edge(8'd0, 8'd4);
        push_edge(8'd255, 8'd1);
        push_edge(8'd0, 8'd1);
        push_edge(8'd2, 8'd3);
        push_edge(8'd1, 8'd3);
        push_edge(8'd0, 8'd2);
        push_edge(8'd9, 8'd9);
        push_start(8'd0, 8'd0);

        // single vertex: complete right after start
        write_vertex_count(9'd1);
        @(negedge clk);
        push_start(8'd0, 8'd0);
        push_edge(8'd0, 8'd0);

        // vertex count lowered in the middle of a graph, then raised again
        write_vertex_count(9'd8);
        @(negedge clk);
        push_start(8'd0, 8'd0);
        push_edge(8'd0, 8'd1);
        push_edge(8'd2, 8'd3);
        push_edge(8'd0, 8'd2);
        push_edge(8'd4, 8'd5);
        push_edge(8'd6, 8'd7);
        write_vertex_count(9'd3);
        @(negedge clk);
        push_edge(8'd0, 8'd4);
        write_vertex_count(9'd8);
        @(negedge clk);
        push_edge(8'd0, 8'd7);
        push_edge(8'd5, 8'd3);
        push_edge(8'd1, 8'd6);

        // random graphs over several vertex counts and idling patterns
        random_phase(9'd2, IDLE_NONE, 60);
        random_phase(NV_W'($urandom_range(16, 3)), IDLE_SENDER, 200);
        random_phase(9'd256, IDLE_RECEIVER, 1);
        random_phase(NV_W'($urandom_range(64, 17)), IDLE_BOTH, 200);
        random_phase(9'd0, IDLE_SENDER, 15);
        random_phase(9'd511, IDLE_BOTH, 1);
        random_phase(NV_W'($urandom_range(40, 2)), IDLE_NONE, 150);
        random_phase(NV_W'($urandom_range(12, 3)), IDLE_RECEIVER, 100);

        wait_quiet();
        mismatch_count += expected_verdicts.size();
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
